### sv/dol_pkg.sv
// Shared constants, codes and item types for the draw-order insertion list.
package dol_pkg;

  localparam int CAPACITY   = 64;
  localparam int COORD_BITS = 16;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int EXT_W      = COORD_BITS + 2;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_DRAIN  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        obj_handle;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         foot_width;
    logic [7:0]         foot_height;
    logic [5:0]         entry_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_handle;
    logic [6:0]  entry_count;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [15:0]           handle;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [7:0]            w;
    logic [7:0]            h;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### sv/dol_ram.sv
// Generic single-port-write, registered-read RAM.
module dol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] store [DEPTH];

  // Write on enable, read every cycle into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[raddr];
  end

endmodule

### sv/dol_order_cmp.sv
// Draw-order test: does the new object go before a stored entry.
module dol_order_cmp (
  input  dol_pkg::entry_t fresh,
  input  dol_pkg::entry_t held,
  output logic            precede
);
  import dol_pkg::*;

  localparam logic signed [EXT_W-1:0] ONE = EXT_W'(1);

  logic signed [EXT_W-1:0] nx, ny, nw, nh, ox, oy, ow, oh;
  logic                    x_apart, y_apart;

  // Sign-extend coordinates, zero-extend footprint sizes
  always_comb begin
    nx = signed'({{2{fresh.x[COORD_BITS-1]}}, fresh.x});
    ny = signed'({{2{fresh.y[COORD_BITS-1]}}, fresh.y});
    ox = signed'({{2{held.x[COORD_BITS-1]}}, held.x});
    oy = signed'({{2{held.y[COORD_BITS-1]}}, held.y});
    nw = signed'({{(EXT_W-8){1'b0}}, fresh.w});
    nh = signed'({{(EXT_W-8){1'b0}}, fresh.h});
    ow = signed'({{(EXT_W-8){1'b0}}, held.w});
    oh = signed'({{(EXT_W-8){1'b0}}, held.h});
  end

  // Footprints span from pos - size + 1 up to pos on each axis
  assign x_apart = (nx - nw + ONE > ox) || (ox - ow + ONE > nx);
  assign y_apart = (ny - nh + ONE > oy) || (oy - oh + ONE > ny);

  // Pick the ordering rule by overlap
  always_comb begin
    if (!x_apart) begin
      precede = (ny < oy);
    end else if (!y_apart) begin
      precede = (nx < ox);
    end else begin
      precede = ((nx + ny) < (ox + oy));
    end
  end

endmodule

### sv/draw_order_insertion_list.sv
// Top level of the draw-order insertion list.
//
// Command channel: cmd is taken at a rising edge with start high and busy low.
// Result channel: each result shows on rsp for one cycle with rsp_valid high;
// the receiver cannot stall, so results simply stream out.
// Entries live in one RAM with a registered read.
//   insert : one pass over the stored entries, reading one entry per cycle
//            and writing the displaced entry one slot up in the same pass;
//            the tail entry is written last, and the result shows in the next cycle.
//   drain  : one read per cycle, one result per cycle.
//   read   : one RAM read, busy while it completes.
//   clear, full insert, out-of-range read, empty drain: no busy time, the
//            result follows on the next cycle.
// Throughput is set by the single RAM read port: about one entry per cycle.
// A new command may be taken in the cycle its predecessor's last result shows.
// Reset (rst, synchronous) empties the list and drops any operation in flight;
// the RAM contents are not cleared, since only written entries are ever read.
module draw_order_insertion_list (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  dol_pkg::cmd_t cmd,
  output logic          rsp_valid,
  output dol_pkg::rsp_t rsp
);
  import dol_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_DRN  = 2'd3;

  logic [1:0]        state, state_next;
  logic [CNT_W-1:0]  total, total_next;
  logic [CNT_W-1:0]  rd_idx, rd_idx_next;
  logic              proc_valid, proc_valid_next;
  logic [ADDR_W-1:0] proc_idx, proc_idx_next;
  logic              placed, placed_next;
  entry_t            carry, carry_next;
  entry_t            item, item_next;
  logic              rsp_valid_next;
  rsp_t              rsp_next;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  entry_t            mem_wdata, mem_rdata;
  logic              precede;

  dol_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dol_order_cmp u_cmp (
    .fresh   (item),
    .held    (mem_rdata),
    .precede (precede)
  );

  assign busy = (state != S_IDLE);

  // Sequence commands and drive the RAM
  always_comb begin
    state_next      = state;
    total_next      = total;
    rd_idx_next     = rd_idx;
    proc_valid_next = 1'b0;
    proc_idx_next   = proc_idx;
    placed_next     = placed;
    carry_next      = carry;
    item_next       = item;
    rsp_valid_next  = 1'b0;
    rsp_next        = rsp;
    mem_we          = 1'b0;
    mem_waddr       = proc_idx;
    mem_wdata       = carry;
    mem_raddr       = rd_idx[ADDR_W-1:0];

    case (state)
      S_IDLE: begin
        mem_raddr = ADDR_W'(cmd.entry_index);
        if (start) begin
          case (cmd.opcode)
            OP_INSERT: begin
              if (total == CNT_W'(CAPACITY)) begin
                rsp_valid_next = 1'b1;
                rsp_next = '{status: ST_FULL, out_handle: '0,
                             entry_count: 7'(total), last: 1'b1};
              end else begin
                item_next.handle = cmd.obj_handle;
                item_next.x      = cmd.pos_x[COORD_BITS-1:0];
                item_next.y      = cmd.pos_y[COORD_BITS-1:0];
                item_next.w      = cmd.foot_width;
                item_next.h      = cmd.foot_height;
                rd_idx_next      = '0;
                placed_next      = 1'b0;
                state_next       = S_INS;
              end
            end
            OP_CLEAR: begin
              total_next     = '0;
              rsp_valid_next = 1'b1;
              rsp_next = '{status: ST_OK, out_handle: '0,
                           entry_count: '0, last: 1'b1};
            end
            OP_READ: begin
              if (int'(cmd.entry_index) < int'(total)) begin
                state_next = S_RD;
              end else begin
                rsp_valid_next = 1'b1;
                rsp_next = '{status: ST_RANGE, out_handle: '0,
                             entry_count: 7'(total), last: 1'b1};
              end
            end
            default: begin
              if (total == '0) begin
                rsp_valid_next = 1'b1;
                rsp_next = '{status: ST_RANGE, out_handle: '0,
                             entry_count: '0, last: 1'b1};
              end else begin
                rd_idx_next = '0;
                state_next  = S_DRN;
              end
            end
          endcase
        end
      end

      S_INS: begin
        // Issue the next read of the pass
        if (rd_idx < total) begin
          rd_idx_next     = rd_idx + CNT_W'(1);
          proc_valid_next = 1'b1;
          proc_idx_next   = rd_idx[ADDR_W-1:0];
        end
        if (proc_valid) begin
          // Shift the displaced entry up, or drop the new one in place
          if (placed) begin
            mem_we     = 1'b1;
            mem_wdata  = carry;
            carry_next = mem_rdata;
          end else if (precede) begin
            mem_we      = 1'b1;
            mem_wdata   = item;
            carry_next  = mem_rdata;
            placed_next = 1'b1;
          end
        end else if (rd_idx == total) begin
          // Pass done: write the tail entry and report
          mem_we         = 1'b1;
          mem_waddr      = total[ADDR_W-1:0];
          mem_wdata      = placed ? carry : item;
          total_next     = total + CNT_W'(1);
          rsp_valid_next = 1'b1;
          rsp_next = '{status: ST_OK, out_handle: '0,
                       entry_count: 7'(total + CNT_W'(1)), last: 1'b1};
          state_next     = S_IDLE;
        end
      end

      S_RD: begin
        rsp_valid_next = 1'b1;
        rsp_next = '{status: ST_OK, out_handle: mem_rdata.handle,
                     entry_count: 7'(total), last: 1'b1};
        state_next = S_IDLE;
      end

      S_DRN: begin
        if (rd_idx < total) begin
          rd_idx_next     = rd_idx + CNT_W'(1);
          proc_valid_next = 1'b1;
          proc_idx_next   = rd_idx[ADDR_W-1:0];
        end
        // Emit one entry per cycle, close out on the final one
        if (proc_valid) begin
          rsp_valid_next = 1'b1;
          rsp_next = '{status: ST_OK, out_handle: mem_rdata.handle,
                       entry_count: '0,
                       last: (CNT_W'(proc_idx) + CNT_W'(1) == total)};
          if (CNT_W'(proc_idx) + CNT_W'(1) == total) begin
            total_next = '0;
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      total      <= '0;
      rd_idx     <= '0;
      proc_valid <= 1'b0;
      placed     <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      total      <= total_next;
      rd_idx     <= rd_idx_next;
      proc_valid <= proc_valid_next;
      placed     <= placed_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    proc_idx <= proc_idx_next;
    carry    <= carry_next;
    item     <= item_next;
    rsp      <= rsp_next;
  end

endmodule

### sv/dol_checker.sv
// Port-level checks for the draw-order insertion list, bound to the top level.
module dol_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input dol_pkg::cmd_t cmd,
  input logic          rsp_valid,
  input dol_pkg::rsp_t rsp
);
  import dol_pkg::*;

  // A dropped insert only happens on a full list
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == 7'(CAPACITY))
    else $error("full status with list not full");

  // Error results carry no handle and end their command
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.out_handle == '0 && rsp.last)
    else $error("error result malformed");

  // A drain streams without gaps
  a_drain_gapless: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |=> rsp_valid)
    else $error("gap inside drain");

  // No new command is taken in the middle of a drain
  a_drain_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> busy)
    else $error("command accepted during drain");

  // A clear answers on the next cycle with an empty list
  a_clear_resp: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.opcode == OP_CLEAR
      |=> rsp_valid && rsp.entry_count == '0 && rsp.last)
    else $error("clear result missing");

endmodule

bind draw_order_insertion_list dol_checker u_dol_checker (.*);

### tb/draw_order_insertion_list_test.sv
// Self-checking testbench for the draw-order insertion list: directed table plus random traffic.
`timescale 1ns / 100ps

module draw_order_insertion_list_test;
  import dol_pkg::*;

  localparam int RAND_ITEMS = 450;

  // One stored object as the list keeps it, coordinates widened for compares
  typedef struct {
    logic [15:0] handle;
    int          x;
    int          y;
    int          w;
    int          h;
  } slot_t;

  // One row of the directed stimulus table
  typedef struct {
    cmd_t c;
    bit   fixed;
    rsp_t r;
  } dir_row_t;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  cmd_t cmd   = '0;
  logic busy;
  logic rsp_valid;
  rsp_t rsp;

  // Predicted list contents and pending results
  slot_t draw_list [CAPACITY];
  int    list_len;
  rsp_t  step_rsp [$];
  rsp_t  awaited_rsp [$];

  dir_row_t dir_tab [$];
  bit       no_idle;
  int       fail_count;
  int       rsp_seen;
  int       n_insert, n_dropped, n_read, n_drain, n_clear, longest_drain;

  draw_order_insertion_list dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stop a hung run
  initial begin
    #6_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic rsp_t mk_rsp(logic [1:0] st, logic [15:0] hd, int cnt, bit lst);
    rsp_t r;
    r.status      = st;
    r.out_handle  = hd;
    r.entry_count = 7'(cnt);
    r.last        = lst;
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic [1:0] op, logic [15:0] hd, int x, int y,
                                      int w, int h, int idx, int fixed,
                                      logic [1:0] st, int rhd, int cnt);
    dir_row_t d;
    d.c.opcode      = op;
    d.c.obj_handle  = hd;
    d.c.pos_x       = 16'(x);
    d.c.pos_y       = 16'(y);
    d.c.foot_width  = 8'(w);
    d.c.foot_height = 8'(h);
    d.c.entry_index = 6'(idx);
    d.fixed         = (fixed != 0);
    d.r             = mk_rsp(st, 16'(rhd), cnt, 1'b1);
    return d;
  endfunction

  // True when object a must be drawn ahead of stored object b
  function automatic bit precedes(slot_t a, slot_t b);
    bit x_apart;
    bit y_apart;
    x_apart = (a.x - a.w + 1 > b.x) || (b.x - b.w + 1 > a.x);
    y_apart = (a.y - a.h + 1 > b.y) || (b.y - b.h + 1 > a.y);
    if (!x_apart) return a.y < b.y;
    if (!y_apart) return a.x < b.x;
    return a.x + a.y < b.x + b.y;
  endfunction

  // Advance the predicted list by one command; results land in step_rsp
  task automatic apply_to_list(input cmd_t c);
    slot_t fresh;
    int    pos;
    int    idx;
    step_rsp.delete();
    case (c.opcode)
      OP_INSERT: begin
        n_insert++;
        if (list_len >= CAPACITY) begin
          n_dropped++;
          step_rsp.insert(step_rsp.size(), mk_rsp(ST_FULL, '0, list_len, 1'b1));
        end else begin
          fresh.handle = c.obj_handle;
          fresh.x      = int'($signed(c.pos_x));
          fresh.y      = int'($signed(c.pos_y));
          fresh.w      = int'(c.foot_width);
          fresh.h      = int'(c.foot_height);
          pos = list_len;
          for (int k = 0; k < list_len; k++) begin
            if (precedes(fresh, draw_list[k])) begin
              pos = k;
              break;
            end
          end
          for (int k = list_len; k > pos; k--) draw_list[k] = draw_list[k-1];
          draw_list[pos] = fresh;
          list_len++;
          step_rsp.insert(step_rsp.size(), mk_rsp(ST_OK, '0, list_len, 1'b1));
        end
      end
      OP_CLEAR: begin
        n_clear++;
        list_len = 0;
        step_rsp.insert(step_rsp.size(), mk_rsp(ST_OK, '0, 0, 1'b1));
      end
      OP_READ: begin
        n_read++;
        idx = int'(c.entry_index);
        if (idx < list_len)
          step_rsp.insert(step_rsp.size(),
                          mk_rsp(ST_OK, draw_list[idx].handle, list_len, 1'b1));
        else
          step_rsp.insert(step_rsp.size(), mk_rsp(ST_RANGE, '0, list_len, 1'b1));
      end
      default: begin
        n_drain++;
        if (list_len == 0) begin
          step_rsp.insert(step_rsp.size(), mk_rsp(ST_RANGE, '0, 0, 1'b1));
        end else begin
          for (int k = 0; k < list_len; k++)
            step_rsp.insert(step_rsp.size(),
                            mk_rsp(ST_OK, draw_list[k].handle, 0, k == list_len - 1));
          if (list_len > longest_drain) longest_drain = list_len;
          list_len = 0;
        end
      end
    endcase
  endtask

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one command, hold it until the transfer, then record what it should produce
  task automatic issue(input cmd_t c, input bit fixed, input rsp_t fixed_rsp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_to_list(c);
    if (fixed) awaited_rsp.insert(awaited_rsp.size(), fixed_rsp);
    else foreach (step_rsp[i]) awaited_rsp.insert(awaited_rsp.size(), step_rsp[i]);
  endtask

  function automatic cmd_t rand_fields();
    cmd_t c;
    c.opcode      = 2'($urandom_range(0, 3));
    c.obj_handle  = 16'($urandom_range(0, 65535));
    c.pos_x       = 16'($urandom_range(0, 65535));
    c.pos_y       = 16'($urandom_range(0, 65535));
    c.foot_width  = 8'($urandom_range(0, 255));
    c.foot_height = 8'($urandom_range(0, 255));
    c.entry_index = 6'($urandom_range(0, 63));
    return c;
  endfunction

  // Cluster most objects near the origin so footprints overlap often
  function automatic cmd_t rand_insert();
    cmd_t c;
    c = rand_fields();
    c.opcode = OP_INSERT;
    if ($urandom_range(0, 3) != 0) begin
      c.pos_x       = 16'(int'($urandom_range(0, 40)) - 20);
      c.pos_y       = 16'(int'($urandom_range(0, 40)) - 20);
      c.foot_width  = 8'($urandom_range(0, 6));
      c.foot_height = 8'($urandom_range(0, 6));
    end
    return c;
  endfunction

  function automatic cmd_t rand_read();
    cmd_t c;
    c = rand_fields();
    c.opcode = OP_READ;
    if ($urandom_range(0, 3) != 0) c.entry_index = 6'($urandom_range(0, list_len > 61 ? 63 : list_len + 2));
    return c;
  endfunction

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && rsp_valid === 1'b1) begin
      rsp_seen++;
      if (awaited_rsp.size() == 0) begin
        $error("unexpected result: status %0d handle %0h count %0d last %0b",
               rsp.status, rsp.out_handle, rsp.entry_count, rsp.last);
        fail_count++;
      end else begin
        exp_r = awaited_rsp.pop_front();
        if (rsp.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, rsp.status);
          fail_count++;
        end
        if (rsp.out_handle !== exp_r.out_handle) begin
          $error("out_handle: expected %0h, got %0h", exp_r.out_handle, rsp.out_handle);
          fail_count++;
        end
        if (rsp.entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.entry_count, rsp.entry_count);
          fail_count++;
        end
        if (rsp.last !== exp_r.last) begin
          $error("last: expected %0b, got %0b", exp_r.last, rsp.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int   sent;
    int   n;
    int   sel;
    bit   first;
    cmd_t c;

    list_len = 0;
    no_idle  = 1'b0;

    // Directed table: extremes, every operation, overlap and empty cases
    dir_tab.insert(dir_tab.size(), mk_row(OP_READ,   16'h0000,      0,      0,   0,   0,  0, 1, ST_RANGE, 0, 0));
    dir_tab.insert(dir_tab.size(), mk_row(OP_DRAIN,  16'h0000,      0,      0,   0,   0,  0, 1, ST_RANGE, 0, 0));
    dir_tab.insert(dir_tab.size(), mk_row(OP_CLEAR,  16'h0000,      0,      0,   0,   0,  0, 1, ST_OK,    0, 0));
    dir_tab.insert(dir_tab.size(), mk_row(OP_INSERT, 16'hFFFF,  32767,  32767, 255, 255, 63, 1, ST_OK,    0, 1));
    dir_tab.insert(dir_tab.size(), mk_row(OP_INSERT, 16'h0000, -32768, -32768,   0,   0,  0, 1, ST_OK,    0, 2));
    dir_tab.insert(dir_tab.size(), mk_row(OP_INSERT, 16'h1111,     10,      5,   4,   2,  0, 0, ST_OK,    0, 0));
    // x footprints overlap
    dir_tab.insert(dir_tab.size(), mk_row(OP_INSERT, 16'h2222,     12,     20,   3,   3,  0, 0, ST_OK,    0, 0));
    // y footprints overlap
    dir_tab.insert(dir_tab.size(), mk_row(OP_INSERT, 16'h3333,     30,      6,   2,   4,  0, 0, ST_OK,    0, 0));
    // zero footprint on both axes
    dir_tab.insert(dir_tab.size(), mk_row(OP_INSERT, 16'h4444,      0,      0,   0,   0,  0, 0, ST_OK,    0, 0));
    // apart on both axes
    dir_tab.insert(dir_tab.size(), mk_row(OP_INSERT, 16'h5555,     -5,    100,   1,   1,  0, 0, ST_OK,    0, 0));
    dir_tab.insert(dir_tab.size(), mk_row(OP_READ,   16'h0000,      0,      0,   0,   0,  0, 0, ST_OK,    0, 0));
    dir_tab.insert(dir_tab.size(), mk_row(OP_READ,   16'h0000,      0,      0,   0,   0,  4, 0, ST_OK,    0, 0));
    dir_tab.insert(dir_tab.size(), mk_row(OP_READ,   16'h0000,      0,      0,   0,   0,  6, 0, ST_OK,    0, 0));
    dir_tab.insert(dir_tab.size(), mk_row(OP_READ,   16'h0000,      0,      0,   0,   0,  7, 1, ST_RANGE, 0, 7));
    dir_tab.insert(dir_tab.size(), mk_row(OP_READ,   16'h0000,      0,      0,   0,   0, 63, 1, ST_RANGE, 0, 7));
    dir_tab.insert(dir_tab.size(), mk_row(OP_DRAIN,  16'h0000,      0,      0,   0,   0,  0, 0, ST_OK,    0, 0));
    dir_tab.insert(dir_tab.size(), mk_row(OP_READ,   16'h0000,      0,      0,   0,   0,  0, 1, ST_RANGE, 0, 0));
    dir_tab.insert(dir_tab.size(), mk_row(OP_INSERT, 16'hA5A5,     -1,     -1,   1,   1,  0, 1, ST_OK,    0, 1));
    // same spot as the stored object: it does not go first
    dir_tab.insert(dir_tab.size(), mk_row(OP_INSERT, 16'h5A5A,     -1,     -1,   1,   1,  0, 0, ST_OK,    0, 0));
    dir_tab.insert(dir_tab.size(), mk_row(OP_CLEAR,  16'h0000,      0,      0,   0,   0,  0, 1, ST_OK,    0, 0));
    dir_tab.insert(dir_tab.size(), mk_row(OP_DRAIN,  16'h0000,      0,      0,   0,   0,  0, 1, ST_RANGE, 0, 0));
    dir_tab.insert(dir_tab.size(), mk_row(OP_INSERT, 16'h0F0F,    100,    100, 255,   0,  0, 1, ST_OK,    0, 1));
    dir_tab.insert(dir_tab.size(), mk_row(OP_INSERT, 16'hF0F0,    100,     50,   0, 255,  0, 0, ST_OK,    0, 0));
    dir_tab.insert(dir_tab.size(), mk_row(OP_DRAIN,  16'h0000,      0,      0,   0,   0,  0, 0, ST_OK,    0, 0));

    // Hold reset, then release it at an edge
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) issue(dir_tab[i].c, dir_tab[i].fixed, dir_tab[i].r);

    // Random phases: a run of inserts with stray reads, some reads, then a drain, a clear or random noise
    sent  = 0;
    first = 1'b1;
    while (sent < RAND_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      n = (first || $urandom_range(0, 4) == 0) ? $urandom_range(64, 70) : $urandom_range(1, 16);
      first = 1'b0;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 4) == 0) issue(rand_read(), 1'b0, '0);
        else issue(rand_insert(), 1'b0, '0);
        sent++;
      end
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        issue(rand_read(), 1'b0, '0);
        sent++;
      end
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        c = rand_fields();
        c.opcode = OP_DRAIN;
        issue(c, 1'b0, '0);
        sent++;
      end else if (sel < 8) begin
        c = rand_fields();
        c.opcode = OP_CLEAR;
        issue(c, 1'b0, '0);
        sent++;
      end else begin
        // noise: fully random commands
        for (int i = 0; i < 3; i++) begin
          issue(rand_fields(), 1'b0, '0);
          sent++;
        end
      end
    end
    start <= 1'b0;

    // Let every expected result arrive, then allow for stragglers
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Sent %0d inserts (%0d dropped on a full list), %0d reads, %0d drains, %0d clears.",
             n_insert, n_dropped, n_read, n_drain, n_clear);
    $display("Checked %0d results; longest drain %0d entries.", rsp_seen, longest_drain);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
